/* hw/rtl/rpn_pkg.sv */
// ----------------------------------------------------------------------------
// RPN calculator package
// Item types, command codes and control structs shared by the calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam logic [2:0] KIND_PUSH   = 3'd0;
  localparam logic [2:0] KIND_ADD    = 3'd1;
  localparam logic [2:0] KIND_MUL    = 3'd2;
  localparam logic [2:0] KIND_DUP    = 3'd3;
  localparam logic [2:0] KIND_NEG    = 3'd4;
  localparam logic [2:0] KIND_RM_NEG = 3'd5;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_FEW  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] operand;
  } rpn_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] top_value;
    logic               top_valid;
    logic [4:0]         depth;
  } rpn_out_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_PUSH,
    DP_DUP,
    DP_NEG,
    DP_READ2,
    DP_CALC,
    DP_WRITE,
    DP_SWEEP_INIT,
    DP_SWEEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] status;
    logic       done;
  } rpn_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_few;
    logic count_full;
    logic sweep_last;
  } rpn_flags_t;

endpackage

/* hw/rtl/rpn_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/rpn_ctrl.sv */
// ----------------------------------------------------------------------------
// RPN calculator controller
// Decodes commands, checks operand counts and sequences the datapath.
// ----------------------------------------------------------------------------
module rpn_ctrl import rpn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] kind,
  input  rpn_flags_t flags,
  output rpn_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CALC  = 4'b0010,
    S_WRITE = 4'b0100,
    S_SWEEP = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd.op     = DP_NOP;
    cmd.status = STAT_DONE;
    cmd.done   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.done = 1'b1;
          case (kind)
            KIND_PUSH: begin
              if (flags.count_full) cmd.status = STAT_FULL;
              else                  cmd.op = DP_PUSH;
            end
            KIND_ADD, KIND_MUL: begin
              if (flags.count_few) begin
                cmd.status = STAT_FEW;
              end else begin
                cmd.op    = DP_READ2;
                cmd.done  = 1'b0;
                state_nxt = S_CALC;
              end
            end
            KIND_DUP: begin
              if (flags.count_zero)      cmd.status = STAT_FEW;
              else if (flags.count_full) cmd.status = STAT_FULL;
              else                       cmd.op = DP_DUP;
            end
            KIND_NEG: begin
              if (flags.count_zero) cmd.status = STAT_FEW;
              else                  cmd.op = DP_NEG;
            end
            KIND_RM_NEG: begin
              if (!flags.count_zero) begin
                cmd.op    = DP_SWEEP_INIT;
                cmd.done  = 1'b0;
                state_nxt = S_SWEEP;
              end
            end
            default: begin
              cmd.op = DP_NOP;
            end
          endcase
        end
      end
      S_CALC: begin
        cmd.op    = DP_CALC;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.op    = DP_WRITE;
        cmd.done  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SWEEP: begin
        cmd.op = DP_SWEEP;
        if (flags.sweep_last) begin
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/rpn_dpath.sv */
// ----------------------------------------------------------------------------
// RPN calculator datapath
// Stack store, cached top entry, arithmetic and result register.
// ----------------------------------------------------------------------------
module rpn_dpath import rpn_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  rpn_in_t    in_item,
  input  rpn_cmd_t   cmd,
  output rpn_flags_t flags,
  output logic       out_valid,
  output rpn_out_t   out_item
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic [CW-1:0] count_r, rd_r, wr_r;
  logic [31:0]   top_r, res_r;
  logic [1:0]    status_r;
  logic          out_valid_r, is_mul_r;

  logic [CW-1:0] count_m1, count_m2, wr_inc;
  logic          we, keep;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata, sum, prod;
  logic [CW+4:0] depth_ext;

  assign count_m1 = count_r - CW'(1);
  assign count_m2 = count_r - CW'(2);
  assign keep     = ~rdata[31];
  assign wr_inc   = wr_r + CW'(keep);
  assign sum      = top_r + rdata;
  assign prod     = top_r * rdata;

  assign flags.count_zero = (count_r == '0);
  assign flags.count_few  = (count_r < CW'(2));
  assign flags.count_full = (count_r == CW'(STACK_DEPTH));
  assign flags.sweep_last = (rd_r == count_r);

  always_comb begin
    we    = 1'b0;
    waddr = count_r[AW-1:0];
    wdata = in_item.operand;
    raddr = rd_r[AW-1:0];
    case (cmd.op)
      DP_PUSH: begin
        we = 1'b1;
      end
      DP_DUP: begin
        we    = 1'b1;
        wdata = top_r;
      end
      DP_NEG: begin
        we    = 1'b1;
        waddr = count_m1[AW-1:0];
        wdata = 32'd0 - top_r;
      end
      DP_READ2: begin
        raddr = count_m2[AW-1:0];
      end
      DP_WRITE: begin
        we    = 1'b1;
        waddr = count_m2[AW-1:0];
        wdata = res_r;
      end
      DP_SWEEP_INIT: begin
        raddr = '0;
      end
      DP_SWEEP: begin
        we    = keep;
        waddr = wr_r[AW-1:0];
        wdata = rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  rpn_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.done;
      case (cmd.op)
        DP_PUSH: begin
          count_r <= count_r + CW'(1);
        end
        DP_DUP: begin
          count_r <= count_r + CW'(1);
        end
        DP_WRITE: begin
          count_r <= count_m1;
        end
        DP_SWEEP: begin
          if (rd_r == count_r) count_r <= wr_inc;
        end
        default: begin
          count_r <= count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) status_r <= cmd.status;
    case (cmd.op)
      DP_PUSH:  top_r <= in_item.operand;
      DP_NEG:   top_r <= 32'd0 - top_r;
      DP_READ2: is_mul_r <= (in_item.kind == KIND_MUL);
      DP_CALC:  res_r <= is_mul_r ? prod : sum;
      DP_WRITE: top_r <= res_r;
      DP_SWEEP_INIT: begin
        rd_r <= CW'(1);
        wr_r <= '0;
      end
      DP_SWEEP: begin
        rd_r <= rd_r + CW'(1);
        wr_r <= wr_inc;
        if (keep) top_r <= rdata;
      end
      default: begin
        top_r <= top_r;
      end
    endcase
  end

  assign depth_ext          = {5'd0, count_r};
  assign out_valid          = out_valid_r;
  assign out_item.status    = status_r;
  assign out_item.top_valid = (count_r != '0);
  assign out_item.top_value = (count_r != '0) ? top_r : 32'sd0;
  assign out_item.depth     = depth_ext[4:0];

endmodule

/* hw/rtl/rpn_stack_calculator.sv */
// ----------------------------------------------------------------------------
// RPN stack calculator
// Bounded operand stack executing one reverse Polish command per item.
// ----------------------------------------------------------------------------
// Drive in_item with start high; the item is taken at a clock edge where
// busy is low. Every item yields one result: out_valid is high for exactly
// one cycle with out_item holding status, top of stack and depth after the
// command. The receiver cannot stall; results are never held.
// Steps from the accepting edge to the result strobe:
//   push, duplicate, negate, rejected, ignored and unused kinds: strobed
//     from the output register, with busy staying low, so one such item per cycle.
//   add and multiply: read second entry, compute, write back.
//   remove negatives: bottom-up sweep keeping non-negatives; none if empty.
// Rate is set by the single read port of the stack RAM, whose read data is
// registered; the top entry is cached in a register beside it.
// Synchronous reset empties the stack; entries need no clearing as only
// entries below the depth are ever used.
// ----------------------------------------------------------------------------
module rpn_stack_calculator import rpn_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  rpn_in_t  in_item,
  output logic     out_valid,
  output rpn_out_t out_item
);

  rpn_cmd_t   cmd;
  rpn_flags_t flags;

  rpn_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .kind  (in_item.kind),
    .flags (flags),
    .cmd   (cmd)
  );

  rpn_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .flags     (flags),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* hw/rtl/rpn_checker.sv */
// ----------------------------------------------------------------------------
// RPN calculator checker
// Port-level properties of the calculator, bound to the top level.
// ----------------------------------------------------------------------------
module rpn_checker import rpn_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input rpn_in_t  in_item,
  input logic     out_valid,
  input rpn_out_t out_item
);

  a_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.kind == KIND_PUSH || in_item.kind == KIND_DUP ||
      in_item.kind == KIND_NEG)) |=> out_valid && !busy)
    else $error("single-cycle command gave no result in the next cycle");

  a_idle_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.top_valid) |-> (out_item.top_value == 32'sd0))
    else $error("empty stack shows non-zero top");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == STAT_DONE || out_item.status == STAT_FEW ||
      out_item.status == STAT_FULL))
    else $error("undefined status code");

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
